// ===== design/tdcc_pkg.sv =====
// Shared types and constants of the TDC code density calibration block.
package tdcc_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CfgW     = 11;
  localparam int unsigned ModReqW  = 3;
  localparam int unsigned ChanW    = 6;
  localparam int unsigned CodeW    = 10;
  localparam int unsigned QVALW    = 17;
  localparam int unsigned TotW     = 32;
  localparam int unsigned LobW     = 10;
  localparam int unsigned FracBits = 16;

  localparam logic [CfgW-1:0]  BinsReset = CfgW'(600);
  localparam logic [QVALW-1:0] Q16One    = QVALW'(65536);
  localparam logic [TotW-1:0]  TotMax    = '1;

  // Action codes
  localparam logic ActRecord = 1'b0;
  localparam logic ActRead   = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_REC   = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_DIV   = 5'b10000
  } seq_state_e;

  // Port enables of the histogram store
  typedef struct packed {
    logic cnt_rd;
    logic cnt_wr;
    logic flag_rd;
    logic flag_wr;
  } mem_ctl_t;

endpackage

// ===== design/tdc_code_density_calibration_unit.sv =====
// Top level: TDC fine-time code density histogram with calibration readout.
// Record item: counter read, then saturating write back; an out-of-range code writes no counter.
// Read item: the walk covers n = effective bin count bins (one bin per cycle
//   through the single counter read port); a Q1.16 divide follows below the last occupied bin.
// Results appear on done_o for exactly one cycle; the receiver cannot stall.
// Reset: a clearing pass over all 2^(mod bits + chan bits + bin bits) addresses (524288 by
//   default) zeroes counters and fired flags; busy stays high until it ends.
module tdc_code_density_calibration_unit #(
  parameter int unsigned MODULES    = 8,
  parameter int unsigned CHANNELS   = 64,
  parameter int unsigned BINS       = 1024,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [tdcc_pkg::ModReqW-1:0]  module_req_i,
  input  logic [tdcc_pkg::ChanW-1:0]    channel_i,
  input  logic [tdcc_pkg::CodeW-1:0]    fine_code_i,
  input  logic                          odd_position_i,
  input  logic [tdcc_pkg::CodeW-1:0]    query_bin_i,
  // result
  output logic                          done_o,
  output logic                          fired_o,
  output logic [tdcc_pkg::QVALW-1:0]    calibration_value_o,
  output logic [tdcc_pkg::TotW-1:0]     hit_total_o,
  output logic [tdcc_pkg::LobW-1:0]     last_occupied_bin_o,
  // configuration: bins_in_use
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tdcc_pkg::CfgW-1:0]     cfg_data_i
);
  import tdcc_pkg::*;

  localparam int unsigned MOD_W  = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned BIN_W  = $clog2(BINS);
  localparam int unsigned NB_W   = $clog2(BINS + 1);
  localparam int unsigned SLOT_W = MOD_W + CH_W;
  localparam int unsigned ADDR_W = SLOT_W + BIN_W;
  localparam int unsigned SUM_W  = COUNT_BITS + BIN_W;
  localparam int unsigned EXT_W  = (SUM_W > TotW) ? SUM_W : TotW;
  localparam int unsigned CMP_W  = (NB_W > CfgW) ? NB_W : CfgW;
  localparam int unsigned IN_W   = (CMP_W > CodeW) ? CMP_W : CodeW;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0] bins_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= BinsReset;
    end else if (cfg_valid_i) begin
      bins_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // effective bin count: min(bins_in_use, BINS)
  logic [NB_W-1:0] n_c;
  always_comb begin
    if (CMP_W'(bins_q) < CMP_W'(BINS)) begin
      n_c = NB_W'(bins_q);
    end else begin
      n_c = NB_W'(BINS);
    end
  end

  // ---------------------------------------------------------------------------
  // Decode of the incoming item
  // ---------------------------------------------------------------------------
  logic              accept;
  logic              addr_ok;
  logic [SLOT_W-1:0] slot_in;
  logic              code_ok;
  logic              qbin_ok;
  logic [BIN_W-1:0]  qsel_in;

  assign accept  = start && !busy;
  assign addr_ok = (32'(module_req_i) < MODULES) && (32'(channel_i) < CHANNELS);
  assign slot_in = {MOD_W'(module_req_i), CH_W'(channel_i)};
  assign code_ok = IN_W'(fine_code_i) < IN_W'(n_c);
  assign qbin_ok = IN_W'(query_bin_i) < IN_W'(n_c);
  // an out-of-range query reads the top bin
  assign qsel_in = qbin_ok ? BIN_W'(query_bin_i) : BIN_W'(n_c - NB_W'(1));

  // ---------------------------------------------------------------------------
  // Sequencer and walk registers
  // ---------------------------------------------------------------------------
  seq_state_e        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [BIN_W-1:0]  qsel_q, qsel_d;
  logic [NB_W-1:0]   n_q, n_d;
  logic [NB_W-1:0]   iss_q, iss_d;
  logic              dv_q, dv_d;
  logic [BIN_W-1:0]  di_q, di_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  cdfq_q, cdfq_d;
  logic [SUM_W-1:0]  cdfbm_q, cdfbm_d;
  logic [BIN_W-1:0]  m_q, m_d;

  // result registers
  logic              done_q, done_d;
  logic              fired_q, fired_d;
  logic [QVALW-1:0]  value_q, value_d;
  logic [TotW-1:0]   total_q, total_d;
  logic [LobW-1:0]   lob_q, lob_d;

  // store interface
  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] cnt_rd_addr;
  logic [ADDR_W-1:0] cnt_wr_addr;
  logic [COUNT_BITS-1:0] cnt_wr_data;
  logic [COUNT_BITS-1:0] cnt_rd_data;
  logic [SLOT_W-1:0] flag_wr_slot;
  logic              flag_wr_val;
  logic              flag_rd_data;

  // divider interface
  logic              div_start;
  logic              div_done;
  logic [QVALW-1:0]  div_quot;

  // walk helpers
  logic [SUM_W-1:0]  cnt_ext;
  logic [SUM_W-1:0]  sum_add;
  logic              walk_end;
  logic [EXT_W-1:0]  tot_ext;
  logic [TotW-1:0]   tot_sat;
  logic              use_div;
  logic [QVALW-1:0]  edge_val;

  assign busy = (state_q != ST_IDLE);

  assign cnt_ext  = SUM_W'(cnt_rd_data);
  assign sum_add  = sum_q + cnt_ext;
  assign walk_end = !dv_q && (iss_q >= n_q);
  assign tot_ext  = EXT_W'(sum_q);
  assign tot_sat  = (tot_ext > EXT_W'(TotMax)) ? TotMax : tot_ext[TotW-1:0];
  // divide only below the last occupied bin of a fired channel
  assign use_div  = flag_rd_data && (m_q != '0) && (qsel_q < m_q);
  // at or past the last occupied bin: 1.0 if any hit lies earlier
  assign edge_val = (flag_rd_data && (m_q != '0) && (cdfbm_q != '0)) ? Q16One : '0;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    addr_d   = addr_q;
    slot_d   = slot_q;
    qsel_d   = qsel_q;
    n_d      = n_q;
    iss_d    = iss_q;
    dv_d     = 1'b0;
    di_d     = di_q;
    sum_d    = sum_q;
    cdfq_d   = cdfq_q;
    cdfbm_d  = cdfbm_q;
    m_d      = m_q;
    done_d   = 1'b0;
    fired_d  = fired_q;
    value_d  = value_q;
    total_d  = total_q;
    lob_d    = lob_q;

    mem_ctl      = '0;
    cnt_rd_addr  = {slot_q, iss_q[BIN_W-1:0]};
    cnt_wr_addr  = addr_q;
    cnt_wr_data  = (cnt_rd_data == '1) ? cnt_rd_data : cnt_rd_data + COUNT_BITS'(1);
    flag_wr_slot = slot_in;
    flag_wr_val  = 1'b1;
    div_start    = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // sweep every counter; clear each flag at bin zero of its slot
        mem_ctl.cnt_wr = 1'b1;
        cnt_wr_addr    = clr_q;
        cnt_wr_data    = '0;
        if (clr_q[BIN_W-1:0] == '0) begin
          mem_ctl.flag_wr = 1'b1;
          flag_wr_slot    = clr_q[ADDR_W-1:BIN_W];
          flag_wr_val     = 1'b0;
        end
        clr_d = clr_q + ADDR_W'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          if (action_i == ActRecord) begin
            if (addr_ok) begin
              mem_ctl.flag_wr = odd_position_i;
              if (code_ok) begin
                mem_ctl.cnt_rd = 1'b1;
                cnt_rd_addr    = {slot_in, BIN_W'(fine_code_i)};
                addr_d         = {slot_in, BIN_W'(fine_code_i)};
                state_d        = ST_REC;
              end
            end
          end else if (addr_ok) begin
            // start the walk: fetch bin zero and the fired flag
            mem_ctl.flag_rd = 1'b1;
            mem_ctl.cnt_rd  = (n_c != '0);
            cnt_rd_addr     = {slot_in, BIN_W'(0)};
            slot_d          = slot_in;
            qsel_d          = qsel_in;
            n_d             = n_c;
            iss_d           = NB_W'(n_c != '0);
            dv_d            = (n_c != '0);
            di_d            = '0;
            sum_d           = '0;
            cdfq_d          = '0;
            cdfbm_d         = '0;
            m_d             = '0;
            state_d         = ST_WALK;
          end else begin
            // unknown address: all-zero result
            done_d  = 1'b1;
            fired_d = 1'b0;
            value_d = '0;
            total_d = '0;
            lob_d   = '0;
          end
        end
      end

      ST_REC: begin
        // write back the saturating increment
        mem_ctl.cnt_wr = 1'b1;
        state_d        = ST_IDLE;
      end

      ST_WALK: begin
        // issue the next bin while the previous one accumulates
        if (iss_q < n_q) begin
          mem_ctl.cnt_rd = 1'b1;
          iss_d          = iss_q + NB_W'(1);
          dv_d           = 1'b1;
          di_d           = iss_q[BIN_W-1:0];
        end
        if (dv_q) begin
          sum_d = sum_add;
          if (di_q == qsel_q) begin
            cdfq_d = sum_add;
          end
          if ((di_q != '0) && (cnt_rd_data != '0)) begin
            m_d     = di_q;
            cdfbm_d = sum_q;
          end
        end
        if (walk_end) begin
          fired_d = flag_rd_data;
          total_d = tot_sat;
          lob_d   = LobW'(m_q);
          if (use_div) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            value_d = edge_val;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          value_d = div_quot;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      dv_q    <= 1'b0;
      iss_q   <= '0;
      n_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      dv_q    <= dv_d;
      iss_q   <= iss_d;
      n_q     <= n_d;
      done_q  <= done_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    slot_q  <= slot_d;
    qsel_q  <= qsel_d;
    di_q    <= di_d;
    sum_q   <= sum_d;
    cdfq_q  <= cdfq_d;
    cdfbm_q <= cdfbm_d;
    m_q     <= m_d;
    fired_q <= fired_d;
    value_q <= value_d;
    total_q <= total_d;
    lob_q   <= lob_d;
  end

  // ---------------------------------------------------------------------------
  // Histogram store and divider
  // ---------------------------------------------------------------------------
  tdcc_hist_mem #(
    .CNT_W  (COUNT_BITS),
    .ADDR_W (ADDR_W),
    .SLOT_W (SLOT_W)
  ) u_mem (
    .clk_i          (clk_i),
    .ctl_i          (mem_ctl),
    .cnt_rd_addr_i  (cnt_rd_addr),
    .cnt_wr_addr_i  (cnt_wr_addr),
    .cnt_wr_data_i  (cnt_wr_data),
    .cnt_rd_data_o  (cnt_rd_data),
    .flag_rd_slot_i (slot_in),
    .flag_wr_slot_i (flag_wr_slot),
    .flag_wr_val_i  (flag_wr_val),
    .flag_rd_data_o (flag_rd_data)
  );

  tdcc_div #(
    .W (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (cdfq_q),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign done_o              = done_q;
  assign fired_o             = fired_q;
  assign calibration_value_o = value_q;
  assign hit_total_o         = total_q;
  assign last_occupied_bin_o = lob_q;

endmodule

// ===== design/tdcc_hist_mem.sv =====
// Histogram counter store and fired-flag store, one read and one write port each.
module tdcc_hist_mem #(
  parameter int unsigned CNT_W  = 32,
  parameter int unsigned ADDR_W = 19,
  parameter int unsigned SLOT_W = 9
) (
  input  logic                clk_i,
  input  tdcc_pkg::mem_ctl_t  ctl_i,
  input  logic [ADDR_W-1:0]   cnt_rd_addr_i,
  input  logic [ADDR_W-1:0]   cnt_wr_addr_i,
  input  logic [CNT_W-1:0]    cnt_wr_data_i,
  output logic [CNT_W-1:0]    cnt_rd_data_o,
  input  logic [SLOT_W-1:0]   flag_rd_slot_i,
  input  logic [SLOT_W-1:0]   flag_wr_slot_i,
  input  logic                flag_wr_val_i,
  output logic                flag_rd_data_o
);
  import tdcc_pkg::*;

  logic [CNT_W-1:0] cnt_mem  [2**ADDR_W];
  logic             flag_mem [2**SLOT_W];
  logic [CNT_W-1:0] cnt_rd_q;
  logic             flag_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.cnt_wr) begin
      cnt_mem[cnt_wr_addr_i] <= cnt_wr_data_i;
    end
    if (ctl_i.cnt_rd) begin
      cnt_rd_q <= cnt_mem[cnt_rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.flag_wr) begin
      flag_mem[flag_wr_slot_i] <= flag_wr_val_i;
    end
    if (ctl_i.flag_rd) begin
      flag_rd_q <= flag_mem[flag_rd_slot_i];
    end
  end

  assign cnt_rd_data_o  = cnt_rd_q;
  assign flag_rd_data_o = flag_rd_q;

endmodule

// ===== design/tdcc_div.sv =====
// Restoring divider giving floor(num * 2^16 / den) for num <= den, one bit a cycle.
module tdcc_div #(
  parameter int unsigned W = 42
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [W-1:0]               num_i,
  input  logic [W-1:0]               den_i,
  output logic                       done_o,
  output logic [tdcc_pkg::QVALW-1:0] quot_o
);
  import tdcc_pkg::*;

  localparam int unsigned CntW = $clog2(FracBits + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [W:0]       rem_q, rem_d;
  logic [W-1:0]     den_q, den_d;
  logic [QVALW-1:0] quot_q, quot_d;
  logic [W:0]       rem_sh;
  logic             ge;

  always_comb begin
    // first step compares without shifting, the rest shift in a zero
    rem_sh = (cnt_q == '0) ? rem_q : {rem_q[W-1:0], 1'b0};
    ge     = rem_sh >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, num_i};
      den_d  = den_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quot_d = {quot_q[QVALW-2:0], ge};
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == CntW'(FracBits)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== test/tb_tdc_code_density_calibration_unit.sv =====
// Self-checking testbench of the TDC code density calibration unit.
module tb_tdc_code_density_calibration_unit;
  import tdcc_pkg::*;

  localparam int unsigned NumSlots = 8 * 64;
  localparam int unsigned NumBins  = 1024;
  localparam int unsigned NumPhase = 12;
  // A read walks every bin and may divide.
  localparam int unsigned ReadTail = 1100;
  // Clearing pass plus ~1900 worst-case reads, taken several times over.
  localparam longint unsigned RunLimit = 64'd50_000_000;

  // One command as it is driven onto the ports
  typedef struct packed {
    bit             action;
    bit [ModReqW-1:0] mod_idx;
    bit [ChanW-1:0] chan;
    bit [CodeW-1:0] code;
    bit             odd;
    bit [CodeW-1:0] qbin;
  } cmd_t;

  // One calibration readout
  typedef struct packed {
    bit             fired;
    bit [QVALW-1:0] value;
    bit [TotW-1:0]  total;
    bit [LobW-1:0]  lob;
  } cal_result_t;

  // Directed row: the command, and a hand-typed readout where one is given
  typedef struct packed {
    cmd_t        cmd;
    bit          typed;
    cal_result_t res;
  } dir_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             action_i;
  logic [ModReqW-1:0] module_req_i;
  logic [ChanW-1:0] channel_i;
  logic [CodeW-1:0] fine_code_i;
  logic             odd_position_i;
  logic [CodeW-1:0] query_bin_i;
  logic             done_o;
  logic             fired_o;
  logic [QVALW-1:0] calibration_value_o;
  logic [TotW-1:0]  hit_total_o;
  logic [LobW-1:0]  last_occupied_bin_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CfgW-1:0]  cfg_data_i;

  // Shadow histogram, fired flags and bin setting of the block
  bit [31:0]   hist_mem [0:NumSlots*NumBins-1];
  bit          fired_mem [0:NumSlots-1];
  bit [CfgW-1:0] bins_cfg = BinsReset;

  cal_result_t cal_expect_q[$];
  dir_row_t    dir_q[$];
  bit [8:0]    hot_slot [4];
  bit [CfgW-1:0] phase_bins [NumPhase];
  int unsigned phase_items [NumPhase];

  int unsigned n_err = 0;
  int unsigned n_rec = 0;
  int unsigned n_read = 0;
  int unsigned n_cfg = 0;
  int unsigned burst_left = 8;

  tdc_code_density_calibration_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .action_i           (action_i),
    .module_req_i       (module_req_i),
    .channel_i          (channel_i),
    .fine_code_i        (fine_code_i),
    .odd_position_i     (odd_position_i),
    .query_bin_i        (query_bin_i),
    .done_o             (done_o),
    .fired_o            (fired_o),
    .calibration_value_o(calibration_value_o),
    .hit_total_o        (hit_total_o),
    .last_occupied_bin_o(last_occupied_bin_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Effective bin count: the setting, clipped to the histogram depth.
  function automatic int unsigned eff_bins();
    return (bins_cfg < NumBins) ? int'(bins_cfg) : NumBins;
  endfunction

  // Add one hit to the shadow histogram; out-of-range codes only mark fired.
  function automatic void record_hit(cmd_t c);
    int unsigned idx;
    idx = {c.mod_idx, c.chan} * NumBins + c.code;
    if (c.code < eff_bins() && hist_mem[idx] != 32'hFFFF_FFFF) begin
      hist_mem[idx] = hist_mem[idx] + 1;
    end
    if (c.odd) begin
      fired_mem[{c.mod_idx, c.chan}] = 1'b1;
    end
  endfunction

  // Work out the normalized cumulative distribution at the queried bin.
  function automatic cal_result_t predict_cal(cmd_t c);
    cal_result_t r;
    int unsigned n, q, m, base;
    longint unsigned sum, cdf_q, cdf_pre;
    r = '0;
    n = eff_bins();
    base = {c.mod_idx, c.chan} * NumBins;
    r.fired = fired_mem[{c.mod_idx, c.chan}];
    m = 0;
    sum = 0;
    cdf_q = 0;
    cdf_pre = 0;
    if (n > 0) begin
      // clamp a query past the counted range onto the top bin
      q = (c.qbin < n) ? int'(c.qbin) : n - 1;
      for (int unsigned k = 1; k < n; k++) begin
        if (hist_mem[base + k] != 0) m = k;
      end
      for (int unsigned k = 0; k < n; k++) begin
        sum += hist_mem[base + k];
        if (k == q) cdf_q = sum;
        if (m >= 1 && k == m - 1) cdf_pre = sum;
      end
      if (r.fired && m >= 1) begin
        if (q < m) begin
          r.value = QVALW'((cdf_q << FracBits) / sum);
        end else begin
          // at or past the last occupied bin: full scale only if earlier hits exist
          r.value = (cdf_pre > 0) ? Q16One : '0;
        end
      end
    end
    r.total = (sum > 64'hFFFF_FFFF) ? TotMax : sum[TotW-1:0];
    r.lob = m[LobW-1:0];
    return r;
  endfunction

  task automatic add_dir_row(input bit act, input int unsigned md, input int unsigned ch,
                             input int unsigned code, input bit odd,
                             input int unsigned qb, input bit typed,
                             input bit e_fired, input int unsigned e_val,
                             input int unsigned e_tot, input int unsigned e_lob);
    dir_row_t row;
    row.cmd.action  = act;
    row.cmd.mod_idx = md[ModReqW-1:0];
    row.cmd.chan    = ch[ChanW-1:0];
    row.cmd.code    = code[CodeW-1:0];
    row.cmd.odd     = odd;
    row.cmd.qbin    = qb[CodeW-1:0];
    row.typed       = typed;
    row.res.fired   = e_fired;
    row.res.value   = e_val[QVALW-1:0];
    row.res.total   = e_tot[TotW-1:0];
    row.res.lob     = e_lob[LobW-1:0];
    dir_q.push_back(row);
  endtask

  // Random command: mostly hot channels with codes and queries in range,
  // the rest anywhere in the field ranges.
  function automatic cmd_t gen_cmd();
    cmd_t c;
    int unsigned n;
    n = eff_bins();
    c.action = ($urandom_range(0, 3) == 0) ? ActRead : ActRecord;
    if ($urandom_range(0, 4) != 0) begin
      {c.mod_idx, c.chan} = hot_slot[$urandom_range(0, 3)];
    end else begin
      {c.mod_idx, c.chan} = 9'($urandom);
    end
    c.code = (n > 0 && $urandom_range(0, 9) < 7) ? CodeW'($urandom_range(0, n - 1))
                                                  : CodeW'($urandom);
    c.odd  = ($urandom_range(0, 4) == 0);
    c.qbin = (n > 0 && $urandom_range(0, 9) < 7) ? CodeW'($urandom_range(0, n - 1))
                                                  : CodeW'($urandom);
    return c;
  endfunction

  // Hold start low until every pending readout has come back.
  task automatic drain_reads();
    @(negedge clk_i);
    start = 1'b0;
    while (cal_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Drive one item, hold it until accepted, then update the shadow state.
  task automatic issue_cmd(input cmd_t c, input bit typed, input cal_result_t typed_res);
    @(negedge clk_i);
    action_i       = c.action;
    module_req_i   = c.mod_idx;
    channel_i      = c.chan;
    fine_code_i    = c.code;
    odd_position_i = c.odd;
    query_bin_i    = c.qbin;
    start          = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (c.action == ActRead) begin
      cal_expect_q.push_back(typed ? typed_res : predict_cal(c));
      n_read++;
    end else begin
      record_hit(c);
      n_rec++;
    end
    // end the burst: drop start for a random gap, sometimes wait for all readouts
    burst_left--;
    if (burst_left == 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    if ($urandom_range(0, 149) == 0) begin
      drain_reads();
    end
  endtask

  // Write the bin setting once the block has gone quiet.
  task automatic write_bins(input bit [CfgW-1:0] v);
    drain_reads();
    // a record leaves no readout behind, so let its write-back finish
    repeat (4) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    cfg_data_i  = v;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    bins_cfg = v;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Compare each strobed readout with the oldest prediction.
  always @(posedge clk_i) begin
    cal_result_t want;
    if (rst_ni && done_o) begin
      if (cal_expect_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) begin
          $display("unexpected readout: fired %0d value %0d total %0d lob %0d",
                   fired_o, calibration_value_o, hit_total_o, last_occupied_bin_o);
        end
      end else begin
        want = cal_expect_q.pop_front();
        if (fired_o !== want.fired || calibration_value_o !== want.value ||
            hit_total_o !== want.total || last_occupied_bin_o !== want.lob) begin
          n_err++;
          if (n_err <= 10) begin
            $display("readout mismatch: fired %0d/%0d value %0d/%0d total %0d/%0d lob %0d/%0d",
                     want.fired, fired_o, want.value, calibration_value_o,
                     want.total, hit_total_o, want.lob, last_occupied_bin_o);
          end
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    cmd_t c;
    start          = 1'b0;
    action_i       = ActRecord;
    module_req_i   = '0;
    channel_i      = '0;
    fine_code_i    = '0;
    odd_position_i = 1'b0;
    query_bin_i    = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset setting of 600 bins.
    // Empty store reads zero, corners of the address space included.
    add_dir_row(ActRead,   0,  0,    0, 0,    0, 1, 0,     0, 0,   0);
    add_dir_row(ActRead,   7, 63,    0, 0, 1023, 1, 0,     0, 0,   0);
    // out-of-range code still marks fired, counts nothing
    add_dir_row(ActRecord, 7, 63, 1023, 1,    0, 0, 0,     0, 0,   0);
    add_dir_row(ActRead,   7, 63,    0, 0, 1023, 1, 1,     0, 0,   0);
    // unfired channel reports total and last bin but value 0
    add_dir_row(ActRecord, 0,  0,    0, 0,    0, 0, 0,     0, 0,   0);
    add_dir_row(ActRecord, 0,  0,    5, 0,    0, 0, 0,     0, 0,   0);
    add_dir_row(ActRead,   0,  0,    0, 0,    0, 1, 0,     0, 2,   5);
    add_dir_row(ActRecord, 0,  0,    5, 1,    0, 0, 0,     0, 0,   0);
    add_dir_row(ActRead,   0,  0,    0, 0,    0, 0, 0,     0, 0,   0);
    add_dir_row(ActRead,   0,  0,    0, 0,    5, 1, 1, 65536, 3,   5);
    // query past the counted range folds onto the top bin
    add_dir_row(ActRead,   0,  0,    0, 0, 1023, 1, 1, 65536, 3,   5);
    // single hit in the top bin: nothing earlier, so the value stays 0
    add_dir_row(ActRecord, 3, 17,  599, 1,    0, 0, 0,     0, 0,   0);
    add_dir_row(ActRead,   3, 17,    0, 0,    0, 1, 1,     0, 1, 599);
    add_dir_row(ActRead,   3, 17,    0, 0,  599, 1, 1,     0, 1, 599);
    add_dir_row(ActRecord, 3, 17,  600, 0,    0, 0, 0,     0, 0,   0);
    add_dir_row(ActRead,   3, 17,    0, 0, 1023, 1, 1,     0, 1, 599);
    // bin 0 never counts as the last occupied bin
    add_dir_row(ActRecord, 5, 42,    1, 1,    0, 0, 0,     0, 0,   0);
    add_dir_row(ActRecord, 5, 42,    1, 0,    0, 0, 0,     0, 0,   0);
    add_dir_row(ActRead,   5, 42,    0, 0,    0, 0, 0,     0, 0,   0);
    add_dir_row(ActRead,   5, 42,    0, 0,    1, 1, 1,     0, 2,   1);
    add_dir_row(ActRecord, 5, 42,    0, 0,    0, 0, 0,     0, 0,   0);
    add_dir_row(ActRead,   5, 42,    0, 0,    0, 0, 0,     0, 0,   0);
    add_dir_row(ActRead,   5, 42,    0, 0,    1, 1, 1, 65536, 3,   1);
    // alternating bit patterns on code and query
    add_dir_row(ActRecord, 2, 21, 'h2AA, 1,    0, 0, 0,     0, 0,   0);
    add_dir_row(ActRecord, 5, 42, 'h155, 0,    0, 0, 0,     0, 0,   0);
    add_dir_row(ActRead,   5, 42,    0, 0, 'h155, 0, 0,     0, 0,   0);
    foreach (dir_q[i]) begin
      row = dir_q[i];
      issue_cmd(row.cmd, row.typed, row.res);
    end

    // Random phases, the extremes of the setting among them.
    phase_bins  = '{2047, 1024, 0, 1, 2, 3, 16, 37, 600, 0, 0, 5};
    phase_items = '{100, 100, 80, 80, 200, 200, 250, 250, 120, 250, 100, 170};
    phase_bins[9]  = CfgW'($urandom_range(4, 64));
    phase_bins[10] = CfgW'($urandom_range(0, 2047));
    for (int p = 0; p < NumPhase; p++) begin
      write_bins(phase_bins[p]);
      foreach (hot_slot[h]) hot_slot[h] = 9'($urandom);
      for (int unsigned i = 0; i < phase_items[p]; i++) begin
        c = gen_cmd();
        issue_cmd(c, 1'b0, '0);
      end
    end

    // Drop start, collect what is pending, then watch for strays.
    drain_reads();
    repeat (ReadTail) @(posedge clk_i);
    $display("run covered %0d records and %0d reads over %0d bin settings,",
             n_rec, n_read, n_cfg);
    $display("from an empty store through 0, 1, 2 and past the 1024-bin depth");
    if (n_err == 0) begin
      $display("tb_tdc_code_density_calibration_unit: done, clean");
    end else begin
      $display("tb_tdc_code_density_calibration_unit: done, errors");
    end
    $finish;
  end

  // Watchdog: stop a hung run.
  initial begin
    #(RunLimit);
    $display("tb_tdc_code_density_calibration_unit: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
design/tdcc_pkg.sv
design/tdcc_hist_mem.sv
design/tdcc_div.sv
design/tdc_code_density_calibration_unit.sv
test/tb_tdc_code_density_calibration_unit.sv
